// File: hw/rtl/rgbafb_pkg.sv
package rgbafb_pkg;

  // register file layout
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = $clog2(NumRegs);
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned FieldW   = 5;
  localparam int unsigned PixelW   = 32;

  typedef logic [FieldW-1:0] cfg_field_t;
  typedef logic [RegIdxW-1:0] reg_idx_t;

  // register indexes
  localparam reg_idx_t RegRedOff   = 3'd0;
  localparam reg_idx_t RegRedLen   = 3'd1;
  localparam reg_idx_t RegGreenOff = 3'd2;
  localparam reg_idx_t RegGreenLen = 3'd3;
  localparam reg_idx_t RegBlueOff  = 3'd4;
  localparam reg_idx_t RegBlueLen  = 3'd5;
  localparam reg_idx_t RegAlphaOff = 3'd6;
  localparam reg_idx_t RegAlphaLen = 3'd7;

  // reset layout: R0/8 G8/8 B16/8, no alpha
  localparam cfg_field_t CfgReset [NumRegs] = '{
    5'd0, 5'd8, 5'd8, 5'd8, 5'd16, 5'd8, 5'd24, 5'd0
  };

  localparam cfg_field_t MaxLen   = 5'd16;
  localparam cfg_field_t ByteLen  = 5'd8;
  localparam cfg_field_t GreenPos = 5'd8;
  localparam cfg_field_t BluePos  = 5'd16;
  localparam cfg_field_t AlphaPos = 5'd24;
  localparam logic [15:0] RoundBias = 16'd127;

  // scale an 8-bit channel to len bits (len clamped to 16)
  function automatic logic [15:0] scale_chan(input logic [7:0] v, input cfg_field_t len);
    cfg_field_t  n;
    logic [15:0] rep;
    logic [15:0] prod;
    logic [15:0] x;
    logic [15:0] q;
    n    = (len > MaxLen) ? MaxLen : len;
    // replicate top bits for 8..16
    rep  = {v, v} >> (MaxLen - n);
    // v*(2^n-1) as a shift and subtract
    prod = ({8'd0, v} << n[2:0]) - {8'd0, v};
    x    = prod + RoundBias;
    // divide by 255: exact for x below 65280, where the sum fits in 16 bits
    q    = (x + (x >> 8) + 16'd1) >> 8;
    if (n == 5'd0) begin
      scale_chan = 16'd0;
    end else if (n >= ByteLen) begin
      scale_chan = rep;
    end else begin
      scale_chan = q;
    end
  endfunction

  // shift a field to its offset, dropping bits above 31
  function automatic logic [PixelW-1:0] place_chan(input logic [15:0] f, input cfg_field_t off);
    place_chan = {16'd0, f} << off;
  endfunction

endpackage

// File: hw/rtl/rgba_to_framebuffer_pixel_pack_core.sv
// RGBA8888 to framebuffer pixel packer
// Input: pulse start_i with source_pixel_i (R in 7:0 .. A in 31:24); a pixel
// transfer happens when start_i is high and busy_o is low. busy_o stays low,
// so one pixel can be taken every clock.
// Output: packed_pixel_o is valid for one cycle while done_o is high; each
// pixel passes the input register, then the result register.
// Throughput is one pixel per cycle, set by the single pass of scale and
// shift logic between the two registers.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// only the low 5 bits of the data are kept, indexes above 7 are ignored.
// cfg_ready_o is always high. Write registers only while no pixel is in
// flight.
// Reset: clears the pipeline valid bits and loads the layout R0/8 G8/8 B16/8
// with no alpha, in which pixels pass through unchanged.
// The receiver cannot stall: done_o must be taken in its cycle.
module rgba_to_framebuffer_pixel_pack_core
  import rgbafb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [PixelW-1:0]   source_pixel_i,
  output logic                done_o,
  output logic [PixelW-1:0]   packed_pixel_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_field_t        cfg_q [NumRegs];
  logic              in_valid_q;
  logic [PixelW-1:0] pixel_q;
  logic              out_valid_q;
  logic [PixelW-1:0] packed_d;
  logic [PixelW-1:0] packed_q;
  logic              cfg_hit;
  logic              direct;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // register write decode
  assign cfg_hit = cfg_valid_i && (cfg_index_i < CfgIdxW'(NumRegs));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        cfg_q[i] <= CfgReset[i];
      end
    end else if (cfg_hit) begin
      cfg_q[cfg_index_i[RegIdxW-1:0]] <= cfg_data_i[FieldW-1:0];
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      pixel_q <= source_pixel_i;
    end
  end

  // pass-through layout detect
  assign direct = (cfg_q[RegRedOff] == 5'd0) && (cfg_q[RegRedLen] == ByteLen) &&
                  (cfg_q[RegGreenOff] == GreenPos) && (cfg_q[RegGreenLen] == ByteLen) &&
                  (cfg_q[RegBlueOff] == BluePos) && (cfg_q[RegBlueLen] == ByteLen) &&
                  ((cfg_q[RegAlphaLen] == 5'd0) ||
                   ((cfg_q[RegAlphaOff] == AlphaPos) && (cfg_q[RegAlphaLen] == ByteLen)));

  // scale each channel and merge into the output word, or copy the pixel for the pass-through layout
  always_comb begin
    if (direct) begin
      packed_d = pixel_q;
    end else begin
      packed_d = place_chan(scale_chan(pixel_q[7:0],   cfg_q[RegRedLen]),   cfg_q[RegRedOff])
               | place_chan(scale_chan(pixel_q[15:8],  cfg_q[RegGreenLen]), cfg_q[RegGreenOff])
               | place_chan(scale_chan(pixel_q[23:16], cfg_q[RegBlueLen]),  cfg_q[RegBlueOff])
               | place_chan(scale_chan(pixel_q[31:24], cfg_q[RegAlphaLen]), cfg_q[RegAlphaOff]);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      packed_q <= packed_d;
    end
  end

  assign done_o         = out_valid_q;
  assign packed_pixel_o = packed_q;

`ifndef NO_ASSERTIONS
  // every pixel transfer yields exactly one result, after the input and result registers
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("pixel transfer lost its result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without a pixel transfer");

  // pass-through layout keeps the pixel bits
  a_direct_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && direct) |=> (packed_pixel_o == $past(pixel_q)))
    else $error("pass-through layout altered the pixel");
`endif

endmodule
